### hdl/dps_pkg.sv
// ----------------------------------------------------------------------------
// dps_pkg: shared types and constants for the delayed pump switch
// Tick counter width, register indexes and reset delays, and the control
// bundle that drives each countdown timer.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int TICKS_W = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_DELAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_HOLD  = 2'd2;

  localparam logic [TICKS_W-1:0] START_DELAY_RST = TICKS_W'(1000 * 6);
  localparam logic [TICKS_W-1:0] STOP_DELAY_RST  = TICKS_W'(1000 * 60 * 5);
  localparam logic [TICKS_W-1:0] FORCE_HOLD_RST  = TICKS_W'(1000 * 60 * 30);

  // Item kinds carried on in_func.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_CMD  = 1'b1;

  typedef logic [TICKS_W-1:0] ticks_t;

  // Per-timer control for one accepted request; at most one field is set.
  typedef struct packed {
    logic tick;
    logic load;
    logic cancel;
  } tmr_ctl_t;

endpackage

### hdl/dps_timer.sv
// ----------------------------------------------------------------------------
// dps_timer: one-shot countdown timer
// Loads a tick count, counts down once per tick and flags expiry on the tick
// that ends the run. A zero load behaves as one.
// ----------------------------------------------------------------------------
module dps_timer
  import dps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  tmr_ctl_t ctl,
  input  ticks_t   load_val,
  output logic     running,
  output logic     expire
);

  logic   running_r, running_nxt;
  ticks_t left_r, left_nxt;
  logic   last_tick;

  assign last_tick = (left_r <= TICKS_W'(1));
  assign expire    = ctl.tick && running_r && last_tick;
  assign running   = running_r;

  always_comb begin
    running_nxt = running_r;
    left_nxt    = left_r;
    if (ctl.load) begin
      running_nxt = 1'b1;
      left_nxt    = load_val;
    end else if (ctl.cancel) begin
      running_nxt = 1'b0;
      left_nxt    = '0;
    end else if (ctl.tick && running_r) begin
      if (last_tick) begin
        running_nxt = 1'b0;
        left_nxt    = '0;
      end else begin
        left_nxt = left_r - TICKS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      left_r    <= '0;
    end else begin
      running_r <= running_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

### hdl/delayed_pump_switch_with_override.sv
// A result is shown in the cycle after its request is accepted.
// Throughput: one request per cycle; the state registers double as the
// result register, so a new request is taken whenever the result is free
// or is taken in the same cycle.
// Reset (synchronous, active low): pump off, all timers idle, delay
// registers back to their default values, no result pending.
// ----------------------------------------------------------------------------
// delayed_pump_switch_with_override: pump drive with delayed switching
// Three countdown timers (start delay, stop delay, forced hold) decide the
// pump level from ticks and on/off commands, plain or forced.
// ----------------------------------------------------------------------------
module delayed_pump_switch_with_override
  import dps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICKS_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic                 in_want_on,
  input  logic                 in_forced,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_pump_drive,
  output logic                 out_start_pending,
  output logic                 out_stop_pending,
  output logic                 out_hold_active
);

  ticks_t   start_delay_r, stop_delay_r, force_hold_r;
  logic     out_valid_r, out_valid_nxt;
  logic     pump_r, pump_nxt;
  logic     accept;
  logic     is_tick, is_cmd;
  tmr_ctl_t start_ctl, stop_ctl, hold_ctl;
  logic     start_run, stop_run, hold_run;
  logic     start_exp, stop_exp, hold_exp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delay_r <= START_DELAY_RST;
      stop_delay_r  <= STOP_DELAY_RST;
      force_hold_r  <= FORCE_HOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_START_DELAY: start_delay_r <= cfg_wdata;
        CFG_STOP_DELAY:  stop_delay_r  <= cfg_wdata;
        CFG_FORCE_HOLD:  force_hold_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The state only moves when a new result replaces the shown one.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_tick  = accept && (in_func == FUNC_TICK);
  assign is_cmd   = accept && (in_func == FUNC_CMD);

  always_comb begin
    start_ctl = '0;
    stop_ctl  = '0;
    hold_ctl  = '0;
    start_ctl.tick = is_tick;
    stop_ctl.tick  = is_tick;
    hold_ctl.tick  = is_tick;
    if (is_cmd) begin
      if (in_want_on) begin
        stop_ctl.cancel = 1'b1;
        if (in_forced) begin
          hold_ctl.load = 1'b1;
        end else begin
          start_ctl.load  = 1'b1;
          hold_ctl.cancel = 1'b1;
        end
      end else if (in_forced) begin
        hold_ctl.cancel = hold_run;
      end else if (!hold_run) begin
        start_ctl.cancel = 1'b1;
        stop_ctl.load    = 1'b1;
      end
    end
  end

  dps_timer u_start (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (start_ctl),
    .load_val (start_delay_r),
    .running  (start_run),
    .expire   (start_exp)
  );

  dps_timer u_stop (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (stop_ctl),
    .load_val (stop_delay_r),
    .running  (stop_run),
    .expire   (stop_exp)
  );

  dps_timer u_hold (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hold_ctl),
    .load_val (force_hold_r),
    .running  (hold_run),
    .expire   (hold_exp)
  );

  always_comb begin
    pump_nxt = pump_r;
    if (is_tick) begin
      // A stop or hold expiry wins over a start expiry on the same tick.
      if (stop_exp || hold_exp) begin
        pump_nxt = 1'b0;
      end else if (start_exp) begin
        pump_nxt = 1'b1;
      end
    end else if (is_cmd) begin
      if (in_want_on && in_forced) begin
        pump_nxt = 1'b1;
      end else if (!in_want_on && in_forced && hold_run) begin
        pump_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pump_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pump_r      <= pump_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pump_drive    = pump_r;
  assign out_start_pending = start_run;
  assign out_stop_pending  = stop_run;
  assign out_hold_active   = hold_run;

endmodule

### hdl/dps_checker.sv
// ----------------------------------------------------------------------------
// dps_checker: port-level checks for the delayed pump switch
// Watches the handshake and the pump and timer flags over time.
// ----------------------------------------------------------------------------
module dps_checker
  import dps_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_func,
  input logic in_want_on,
  input logic in_forced,
  input logic out_valid,
  input logic out_ready,
  input logic out_pump_drive,
  input logic out_start_pending,
  input logic out_stop_pending,
  input logic out_hold_active
);

  // A result stays up until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // A forced on shows up in the very next result.
  a_forced_on: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_CMD) && in_want_on && in_forced
    |=> out_valid && out_pump_drive && out_hold_active && !out_stop_pending)
    else $error("forced on request not reflected in result");

  // The forced hold always runs with the pump on and no stop pending.
  a_hold_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hold_active |-> out_pump_drive && !out_stop_pending)
    else $error("hold active without pump running");

  // Start and stop delays cancel each other.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_start_pending && out_stop_pending))
    else $error("start and stop delay pending together");

endmodule

bind delayed_pump_switch_with_override dps_checker u_dps_checker (.*);
